/* hw/rtl/plcp_header_field_calc_unit_assert.svh */
// Assertion macros for the PLCP header field calculator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PLCP_HEADER_FIELD_CALC_UNIT_ASSERT_SVH
`define PLCP_HEADER_FIELD_CALC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset
`define PLCP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge out of reset
`define PLCP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLCP_ASSERT_IMP(label, ante, cons, msg)
`define PLCP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

/* hw/rtl/plcp_pkg.sv */
// Shared types, codes and constants for the PLCP header field calculator.
// No dependencies; the interfaces and modules of the block import this package.
package plcp_pkg;

  // Field types
  typedef logic [11:0] frame_bytes_t;
  typedef logic [3:0]  rate_index_t;
  typedef logic [1:0]  packet_kind_t;
  typedef logic [7:0]  signal_t;
  typedef logic [7:0]  service_t;
  typedef logic [14:0] plcp_len_t;

  localparam int LEN_OUT_W = $bits(plcp_len_t);

  // Packet kinds
  localparam packet_kind_t KIND_11A = 2'd0;
  localparam packet_kind_t KIND_11B = 2'd1;

  // Rate indexes
  localparam rate_index_t RATE_1M        = 4'd0;
  localparam rate_index_t RATE_2M        = 4'd1;
  localparam rate_index_t RATE_5M5       = 4'd2;
  localparam rate_index_t RATE_CCK11     = 4'd3;
  localparam rate_index_t RATE_OFDM_BASE = 4'd4;
  localparam rate_index_t RATE_OFDM_TOP  = 4'd11;

  localparam logic [2:0] OFDM_IDX_MAX = 3'd7;

  // Rate class carried down the pipeline
  typedef enum logic [2:0] {
    RC_DSSS1 = 3'd0,
    RC_DSSS2 = 3'd1,
    RC_CCK5  = 3'd2,
    RC_CCK11 = 3'd3,
    RC_OFDM  = 3'd4
  } rate_cls_t;

  // SIGNAL codes
  localparam signal_t SIG_1M          = 8'h00;
  localparam signal_t SIG_2M_LONG     = 8'h01;
  localparam signal_t SIG_2M_SHORT    = 8'h09;
  localparam signal_t SIG_5M5_LONG    = 8'h02;
  localparam signal_t SIG_5M5_SHORT   = 8'h0a;
  localparam signal_t SIG_11M_LONG    = 8'h03;
  localparam signal_t SIG_11M_SHORT   = 8'h0b;
  localparam signal_t SIG_OFDM_11A    = 8'h90;
  localparam signal_t SIG_OFDM_OTHER  = 8'h80;

  // SERVICE length extension
  localparam service_t SERVICE_LEN_EXT = 8'h80;
  localparam service_t SERVICE_NONE    = 8'h00;

  // Divide by 11: q ~= (n * DIV_RECIP) >> DIV_RECIP_SHIFT, low by at most one
  localparam int DIVISOR         = 11;
  localparam int DIV_RECIP       = 23831;
  localparam int DIV_RECIP_W     = 15;
  localparam int DIV_RECIP_SHIFT = 18;
  localparam int REM_W           = 5;
  localparam int EXT_REM_MAX     = 3;
  localparam int NUM_BIAS_5M5    = 10;

  // Control group handed from stage to stage
  typedef struct packed {
    rate_cls_t rate_cls;
    logic      is_11b;
    signal_t   signal;
  } plcp_ctrl_t;

  // Rate nibble of the OFDM SIGNAL field, 6M first
  function automatic signal_t ofdm_rate_code(logic [2:0] idx);
    signal_t code;
    case (idx)
      3'd0:    code = 8'h0b;
      3'd1:    code = 8'h0f;
      3'd2:    code = 8'h0a;
      3'd3:    code = 8'h0e;
      3'd4:    code = 8'h09;
      3'd5:    code = 8'h0d;
      3'd6:    code = 8'h08;
      default: code = 8'h0c;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/plcp_if.sv */
// Valid/ready channel interfaces for frame descriptors and PLCP results.
// Depends on plcp_pkg for the payload types.
interface plcp_in_if;
  import plcp_pkg::*;

  logic         valid;
  logic         ready;
  frame_bytes_t frame_bytes;
  rate_index_t  rate_index;
  packet_kind_t packet_kind;

  modport source (output valid, output frame_bytes, output rate_index,
                  output packet_kind, input ready);
  modport sink   (input valid, input frame_bytes, input rate_index,
                  input packet_kind, output ready);
endinterface

interface plcp_out_if;
  import plcp_pkg::*;

  logic      valid;
  logic      ready;
  signal_t   plcp_signal;
  service_t  plcp_service;
  plcp_len_t plcp_length;

  modport source (output valid, output plcp_signal, output plcp_service,
                  output plcp_length, input ready);
  modport sink   (input valid, input plcp_signal, input plcp_service,
                  input plcp_length, output ready);
endinterface

/* hw/rtl/plcp_decode.sv */
// Stage 1: decode rate and kind, look up SIGNAL, form the divide-by-11 numerator.
// Depends on plcp_pkg and plcp_in_if.
module plcp_decode #(
  parameter int LENGTH_WIDTH = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       short_preamble,
  plcp_in_if.sink                    in_ch,
  output logic                       valid_o,
  input  logic                       ready_i,
  output plcp_pkg::plcp_ctrl_t       ctrl_o,
  output logic [LENGTH_WIDTH-1:0]    bytes_o,
  output logic [LENGTH_WIDTH+3:0]    num_o
);
  import plcp_pkg::*;

  localparam int NUM_W = LENGTH_WIDTH + 4;

  logic                    valid_r;
  plcp_ctrl_t              ctrl_r;
  plcp_ctrl_t              ctrl_nxt;
  logic [LENGTH_WIDTH-1:0] bytes_r;
  logic [LENGTH_WIDTH-1:0] bytes_nxt;
  logic [NUM_W-1:0]        num_r;
  logic [NUM_W-1:0]        num_nxt;
  logic [2:0]              ofdm_idx;
  logic                    stage_ready;

  // Keep the low LENGTH_WIDTH bits of the byte count
  assign bytes_nxt = LENGTH_WIDTH'(in_ch.frame_bytes);

  // Clamp rate indexes above 54M onto the 54M entry
  assign ofdm_idx = (in_ch.rate_index > RATE_OFDM_TOP) ? OFDM_IDX_MAX :
                    3'(in_ch.rate_index - RATE_OFDM_BASE);

  // Decode rate class and SIGNAL code
  always_comb begin
    ctrl_nxt.is_11b = (in_ch.packet_kind == KIND_11B);
    unique case (in_ch.rate_index)
      RATE_1M: begin
        ctrl_nxt.rate_cls = RC_DSSS1;
        ctrl_nxt.signal   = SIG_1M;
      end
      RATE_2M: begin
        ctrl_nxt.rate_cls = RC_DSSS2;
        ctrl_nxt.signal   = short_preamble ? SIG_2M_SHORT : SIG_2M_LONG;
      end
      RATE_5M5: begin
        ctrl_nxt.rate_cls = RC_CCK5;
        ctrl_nxt.signal   = short_preamble ? SIG_5M5_SHORT : SIG_5M5_LONG;
      end
      RATE_CCK11: begin
        ctrl_nxt.rate_cls = RC_CCK11;
        ctrl_nxt.signal   = short_preamble ? SIG_11M_SHORT : SIG_11M_LONG;
      end
      default: begin
        ctrl_nxt.rate_cls = RC_OFDM;
        ctrl_nxt.signal   = ofdm_rate_code(ofdm_idx) |
                            ((in_ch.packet_kind == KIND_11A) ? SIG_OFDM_11A
                                                             : SIG_OFDM_OTHER);
      end
    endcase
  end

  // Numerator: 2*bits + 10 at 5.5M (ceiling of 2*bits/11), bits otherwise
  assign num_nxt = (in_ch.rate_index == RATE_5M5) ?
                   NUM_W'({bytes_nxt, 4'b0000}) + NUM_W'(NUM_BIAS_5M5) :
                   NUM_W'({bytes_nxt, 3'b000});

  // Advance when empty or when the next stage takes the held item
  assign stage_ready = !valid_r || ready_i;
  assign in_ch.ready = stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stage_ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && in_ch.valid) begin
      ctrl_r  <= ctrl_nxt;
      bytes_r <= bytes_nxt;
      num_r   <= num_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctrl_o  = ctrl_r;
  assign bytes_o = bytes_r;
  assign num_o   = num_r;

endmodule

/* hw/rtl/plcp_div11.sv */
// Stages 2 and 3: divide the numerator by 11 with a reciprocal multiply,
// then form the estimated remainder. Depends on plcp_pkg.
module plcp_div11 #(
  parameter int LENGTH_WIDTH = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  plcp_pkg::plcp_ctrl_t       ctrl_i,
  input  logic [LENGTH_WIDTH-1:0]    bytes_i,
  input  logic [LENGTH_WIDTH+3:0]    num_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output plcp_pkg::plcp_ctrl_t       ctrl_o,
  output logic [LENGTH_WIDTH-1:0]    bytes_o,
  output logic [LENGTH_WIDTH+3:0]    quot_o,
  output logic [plcp_pkg::REM_W-1:0] rem_o
);
  import plcp_pkg::*;

  localparam int NUM_W  = LENGTH_WIDTH + 4;
  localparam int PROD_W = NUM_W + DIV_RECIP_W;

  // Stage 2: product
  logic                    s2_valid_r;
  plcp_ctrl_t              s2_ctrl_r;
  logic [LENGTH_WIDTH-1:0] s2_bytes_r;
  logic [NUM_W-1:0]        s2_num_r;
  logic [PROD_W-1:0]       s2_prod_r;
  logic [PROD_W-1:0]       s2_prod_nxt;
  logic                    s2_ready;

  // Stage 3: quotient estimate and remainder
  logic                    s3_valid_r;
  plcp_ctrl_t              s3_ctrl_r;
  logic [LENGTH_WIDTH-1:0] s3_bytes_r;
  logic [NUM_W-1:0]        s3_quot_r;
  logic [NUM_W-1:0]        s3_quot_nxt;
  logic [REM_W-1:0]        s3_rem_r;
  logic [REM_W-1:0]        s3_rem_nxt;
  logic [NUM_W-1:0]        s3_diff;
  logic                    s3_ready;

  assign s3_ready = !s3_valid_r || ready_i;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign ready_o  = s2_ready;

  // Multiply by the scaled reciprocal of 11
  assign s2_prod_nxt = PROD_W'(num_i) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && valid_i) begin
      s2_ctrl_r  <= ctrl_i;
      s2_bytes_r <= bytes_i;
      s2_num_r   <= num_i;
      s2_prod_r  <= s2_prod_nxt;
    end
  end

  // Quotient estimate is exact or one low, so the remainder stays below 22
  assign s3_quot_nxt = NUM_W'(s2_prod_r >> DIV_RECIP_SHIFT);
  assign s3_diff     = s2_num_r - NUM_W'(s3_quot_nxt * NUM_W'(DIVISOR));
  assign s3_rem_nxt  = REM_W'(s3_diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      s3_ctrl_r  <= s2_ctrl_r;
      s3_bytes_r <= s2_bytes_r;
      s3_quot_r  <= s3_quot_nxt;
      s3_rem_r   <= s3_rem_nxt;
    end
  end

  assign valid_o = s3_valid_r;
  assign ctrl_o  = s3_ctrl_r;
  assign bytes_o = s3_bytes_r;
  assign quot_o  = s3_quot_r;
  assign rem_o   = s3_rem_r;

endmodule

/* hw/rtl/plcp_format.sv */
// Stage 4: correct the quotient, pick LENGTH and SERVICE, hold the result
// in the output register. Depends on plcp_pkg and plcp_out_if.
module plcp_format #(
  parameter int LENGTH_WIDTH = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  plcp_pkg::plcp_ctrl_t       ctrl_i,
  input  logic [LENGTH_WIDTH-1:0]    bytes_i,
  input  logic [LENGTH_WIDTH+3:0]    quot_i,
  input  logic [plcp_pkg::REM_W-1:0] rem_i,
  plcp_out_if.source                 out_ch
);
  import plcp_pkg::*;

  localparam int NUM_W = LENGTH_WIDTH + 4;

  logic             valid_r;
  signal_t          signal_r;
  service_t         service_r;
  service_t         service_nxt;
  plcp_len_t        length_r;
  plcp_len_t        length_nxt;
  logic             fix;
  logic [NUM_W-1:0] quot;
  logic [REM_W-1:0] rem;
  logic             rem_nz;
  logic             stage_ready;

  // Bump a one-low quotient estimate
  assign fix    = (rem_i >= REM_W'(DIVISOR));
  assign quot   = fix ? quot_i + NUM_W'(1) : quot_i;
  assign rem    = fix ? rem_i - REM_W'(DIVISOR) : rem_i;
  assign rem_nz = (rem != '0);

  // Select LENGTH and SERVICE
  always_comb begin
    service_nxt = SERVICE_NONE;
    if (!ctrl_i.is_11b) begin
      length_nxt = LEN_OUT_W'(bytes_i);
    end else begin
      case (ctrl_i.rate_cls)
        RC_DSSS1: length_nxt = LEN_OUT_W'({bytes_i, 3'b000});
        RC_DSSS2: length_nxt = LEN_OUT_W'({bytes_i, 2'b00});
        RC_CCK5:  length_nxt = LEN_OUT_W'(quot);
        RC_CCK11: begin
          length_nxt = LEN_OUT_W'(quot + NUM_W'(rem_nz));
          if (rem_nz && (rem <= REM_W'(EXT_REM_MAX))) begin
            service_nxt = SERVICE_LEN_EXT;
          end
        end
        default:  length_nxt = '0;
      endcase
    end
  end

  // Output register: load when empty or when the sink takes the result
  assign stage_ready = !valid_r || out_ch.ready;
  assign ready_o     = stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stage_ready) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && valid_i) begin
      signal_r  <= ctrl_i.signal;
      service_r <= service_nxt;
      length_r  <= length_nxt;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.plcp_signal  = signal_r;
  assign out_ch.plcp_service = service_r;
  assign out_ch.plcp_length  = length_r;

endmodule

/* hw/rtl/plcp_header_field_calc_unit.sv */
// PLCP header field calculator: SIGNAL, SERVICE and LENGTH per transmit frame.
// Structure: 4 register stages (decode, reciprocal multiply, remainder, correct and
// select); an input transfer passes through them in that order to the output.
// Throughput: one frame per cycle; a stalled output holds the pipe in place.
// Reset clears all stage valid bits and short_preamble (long preamble codes).
`include "plcp_header_field_calc_unit_assert.svh"

module plcp_header_field_calc_unit #(
  parameter int LENGTH_WIDTH = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  plcp_in_if.sink      in_ch,
  plcp_out_if.source   out_ch,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);
  import plcp_pkg::*;

  localparam int NUM_W = LENGTH_WIDTH + 4;

  logic                    short_preamble_r;

  logic                    s1_valid;
  logic                    s1_ready;
  plcp_ctrl_t              s1_ctrl;
  logic [LENGTH_WIDTH-1:0] s1_bytes;
  logic [NUM_W-1:0]        s1_num;

  logic                    s3_valid;
  logic                    s3_ready;
  plcp_ctrl_t              s3_ctrl;
  logic [LENGTH_WIDTH-1:0] s3_bytes;
  logic [NUM_W-1:0]        s3_quot;
  logic [REM_W-1:0]        s3_rem;

  // Preamble setting register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_preamble_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      short_preamble_r <= cfg_data;
    end
  end

  plcp_decode #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .short_preamble (short_preamble_r),
    .in_ch          (in_ch),
    .valid_o        (s1_valid),
    .ready_i        (s1_ready),
    .ctrl_o         (s1_ctrl),
    .bytes_o        (s1_bytes),
    .num_o          (s1_num)
  );

  plcp_div11 #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_div11 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .ctrl_i  (s1_ctrl),
    .bytes_i (s1_bytes),
    .num_i   (s1_num),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .ctrl_o  (s3_ctrl),
    .bytes_o (s3_bytes),
    .quot_o  (s3_quot),
    .rem_o   (s3_rem)
  );

  plcp_format #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_format (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .ctrl_i  (s3_ctrl),
    .bytes_i (s3_bytes),
    .quot_i  (s3_quot),
    .rem_i   (s3_rem),
    .out_ch  (out_ch)
  );

  // Checks
  logic in_go;
  logic flow_ok;

  assign in_go   = rst_n && in_ch.valid && in_ch.ready;
  assign flow_ok = rst_n && out_ch.ready;

  // Back-pressure at the input only comes from a full, stalled pipe
  `PLCP_ASSERT_IMP(a_stall_source, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled while output free")
  // With the sink ready all along, an input transfer shows up as a valid result at the output
  `PLCP_ASSERT_IMP(a_latency, $past(in_go, 4) && $past(flow_ok, 1) && $past(flow_ok, 2) && $past(flow_ok, 3), out_ch.valid, "result late")
  // A configuration transfer lands in the preamble register
  `PLCP_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready, short_preamble_r == $past(cfg_data), "cfg lost")

endmodule
